>>> src/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the power test statistics unit
// Beat layouts of both channels, command, kind, phase and register codes,
// reset values, constants, and the shared divider's widths and beat types.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

  // Commands
  localparam logic [1:0] CMD_START    = 2'd0;
  localparam logic [1:0] CMD_PHASE    = 2'd1;
  localparam logic [1:0] CMD_SAMPLE   = 2'd2;
  localparam logic [1:0] CMD_FINALIZE = 2'd3;

  // Test kinds
  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_RAMP     = 2'd1;
  localparam logic [1:0] KIND_LONG     = 2'd2;
  localparam logic [1:0] KIND_RECOVERY = 2'd3;

  // Phases
  localparam logic [2:0] PH_WARMUP  = 3'd0;
  localparam logic [2:0] PH_MAIN    = 3'd1;
  localparam logic [2:0] PH_COOL    = 3'd2;
  localparam logic [2:0] PH_LOAD    = 3'd3;
  localparam logic [2:0] PH_RECOVER = 3'd4;
  localparam logic [2:0] PH_IDLE    = 3'd5;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_PCT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PCT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_DROP = 2'd3;

  // Register reset values
  localparam logic [15:0] GAP_RST      = 16'd900;
  localparam logic [6:0]  RAMP_PCT_RST = 7'd75;
  localparam logic [6:0]  LONG_PCT_RST = 7'd95;
  localparam logic [7:0]  DROP_RST     = 8'd40;

  // Arithmetic constants
  localparam logic [19:0] PCT_ROUND   = 20'd50;
  localparam logic [15:0] PCT_DIV     = 16'd100;
  localparam logic [3:0]  GRADE_STEPS = 4'd9;
  localparam logic [3:0]  GRADE_MAX   = 4'd10;
  localparam logic [15:0] MS_PER_S    = 16'd1000;
  localparam logic [11:0] WATTS_MAX   = 12'hFFF;

  // Shared divider
  localparam int unsigned DIV_NUM_W = 32;
  localparam int unsigned DIV_DEN_W = 16;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  test_kind;
    logic [2:0]  phase_code;
    logic [11:0] power_watts;
    logic [7:0]  heart_rate;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [11:0] peak_watts;
    logic [11:0] best_mean_watts;
    logic [11:0] main_avg_watts;
    logic [15:0] main_sample_count;
    logic [7:0]  hr_at_load;
    logic [7:0]  hr_at_recover;
    logic [11:0] ftp_proposal;
    logic [3:0]  recovery_grade;
    logic [22:0] duration_s;
  } out_item_t;

endpackage

`default_nettype wire

>>> src/power_test_statistics_unit.sv
// ----------------------------------------------------------------------------
// power_test_statistics_unit: power test scoring
// Command-driven statistics for ramp, long and recovery tests:
// peak, sliding-window best mean, main-phase average, FTP proposal,
// recovery grade and duration, emitted as one result beat on finalize.
// ----------------------------------------------------------------------------
//  channel | ports                         | beat
//  --------+-------------------------------+----------------------------------
//  input   | in_valid, in_stall, in_data   | one command (in_item_t)
//  result  | out_valid, out_stall, out_data| one score on finalize (out_item_t)
//  config  | cfg_wr_en, cfg_index, cfg_wdata| one register write
//
//  Start, phase and dropped samples finish in S_IDLE; a kept sample passes
//  S_SMP_UPD and, when the window is full, one divider pass in S_WIN_WT.
//  Finalize makes up to four divider passes for a ramp test (fallback,
//  average, FTP, duration), three for a long test and two for recovery.
//  in_stall is high while an item is in work; the result register holds a
//  stalled result and the next item is taken meanwhile, but a following
//  finalize waits in S_OUT until that result is taken. Reset is
//  synchronous; the window memory needs no clearing (the fill count gates it).
// ----------------------------------------------------------------------------
`default_nettype none

module power_test_statistics_unit #(
  parameter int unsigned WINDOW = 60
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire pts_pkg::in_item_t                  in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output pts_pkg::out_item_t                      out_data,
  input  wire logic                               cfg_wr_en,
  input  wire logic [pts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pts_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import pts_pkg::*;

  localparam int unsigned POS_W  = $clog2(WINDOW);
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned TOT_W  = 12 + FILL_W;
  localparam logic [FILL_W-1:0]    WIN_FULL = FILL_W'(WINDOW);
  localparam logic [POS_W-1:0]     POS_LAST = POS_W'(WINDOW - 1);
  localparam logic [DIV_DEN_W-1:0] WIN_DIV  = DIV_DEN_W'(WINDOW);

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_SMP_UPD = 15'b000000000000010,
    S_WIN_WT  = 15'b000000000000100,
    S_FB_GO   = 15'b000000000001000,
    S_FB_WT   = 15'b000000000010000,
    S_AVG_GO  = 15'b000000000100000,
    S_AVG_WT  = 15'b000000001000000,
    S_FTP_GO  = 15'b000000010000000,
    S_FTP_WT  = 15'b000000100000000,
    S_GRD_GO  = 15'b000001000000000,
    S_GRD_WT  = 15'b000010000000000,
    S_DUR_GO  = 15'b000100000000000,
    S_DUR_WT  = 15'b001000000000000,
    S_OUT     = 15'b010000000000000,
    S_SPARE   = 15'b100000000000000
  } st_t;

  // configuration
  logic [15:0] gap_r;
  logic [6:0]  ramp_pct_r;
  logic [6:0]  long_pct_r;
  logic [7:0]  drop_r;

  // sequencer and test state
  st_t               st_r, st_nxt;
  in_item_t          in_r;
  logic [1:0]        kind_r, kind_nxt;
  logic [2:0]        phase_r, phase_nxt;
  logic [31:0]       start_r, start_nxt;
  logic [31:0]       last_r, last_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [11:0]       best_r, best_nxt;
  logic [31:0]       mtot_r, mtot_nxt;
  logic [15:0]       mcnt_r, mcnt_nxt;
  logic [11:0]       peak_r, peak_nxt;
  logic [7:0]        hr_first_r, hr_first_nxt;
  logic [7:0]        hr_last_r, hr_last_nxt;
  logic              armed_r, armed_nxt;
  logic [11:0]       mean_r, mean_nxt;
  logic [11:0]       avg_r, avg_nxt;
  logic [11:0]       ftp_r, ftp_nxt;
  logic [3:0]        grade_r, grade_nxt;
  logic [22:0]       dur_r, dur_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic [11:0] win_mem [WINDOW];
  logic [11:0] rd_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        acc;
  logic [2:0]  ph_map;
  logic        gap_ok;
  logic [32:0] msum;
  logic [TOT_W-1:0] tot_upd;
  logic [FILL_W-1:0] fill_upd;
  logic [11:0] ftp_val;
  logic [6:0]  ftp_pct;
  logic [18:0] ftp_prod;
  logic [7:0]  hr_drop;
  logic        grade_ok;

  assign acc       = in_valid && !in_stall;
  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  pts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // phase a command maps to for the running test kind
  always_comb begin
    if (kind_r == KIND_RAMP) begin
      ph_map = PH_MAIN;
    end else if (kind_r == KIND_LONG) begin
      ph_map = (in_data.phase_code <= PH_COOL) ? in_data.phase_code : PH_WARMUP;
    end else begin
      ph_map = (in_data.phase_code == PH_RECOVER) ? PH_RECOVER : PH_LOAD;
    end
  end

  assign gap_ok   = (last_r == '0) || ((in_data.now_ms - last_r) >= {16'd0, gap_r});
  assign msum     = {1'b0, mtot_r} + 33'(in_data.power_watts);
  assign tot_upd  = ((fill_r == WIN_FULL) ? (total_r - TOT_W'(rd_r)) : total_r)
                    + TOT_W'(in_r.power_watts);
  assign fill_upd = (fill_r == WIN_FULL) ? fill_r : fill_r + 1'b1;
  assign ftp_val  = (kind_r == KIND_RAMP) ? ((best_r != '0) ? best_r : peak_r)
                    : ((kind_r == KIND_LONG) ? avg_r : 12'd0);
  assign ftp_pct  = (kind_r == KIND_RAMP) ? ramp_pct_r : long_pct_r;
  assign ftp_prod = 19'(ftp_val) * 19'(ftp_pct);
  assign hr_drop  = hr_first_r - hr_last_r;
  assign grade_ok = (kind_r == KIND_RECOVERY) && (hr_first_r != '0) &&
                    (hr_last_r != '0) && (hr_first_r >= hr_last_r);

  always_comb begin
    st_nxt        = st_r;
    kind_nxt      = kind_r;
    phase_nxt     = phase_r;
    start_nxt     = start_r;
    last_nxt      = last_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    best_nxt      = best_r;
    mtot_nxt      = mtot_r;
    mcnt_nxt      = mcnt_r;
    peak_nxt      = peak_r;
    hr_first_nxt  = hr_first_r;
    hr_last_nxt   = hr_last_r;
    armed_nxt     = armed_r;
    mean_nxt      = mean_r;
    avg_nxt       = avg_r;
    ftp_nxt       = ftp_r;
    grade_nxt     = grade_r;
    dur_nxt       = dur_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    div_req       = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      S_IDLE: begin
        if (acc) begin
          if (in_data.command == CMD_START) begin
            kind_nxt     = KIND_NONE;
            phase_nxt    = PH_IDLE;
            start_nxt    = '0;
            last_nxt     = '0;
            pos_nxt      = '0;
            fill_nxt     = '0;
            total_nxt    = '0;
            best_nxt     = '0;
            mtot_nxt     = '0;
            mcnt_nxt     = '0;
            peak_nxt     = '0;
            hr_first_nxt = '0;
            hr_last_nxt  = '0;
            armed_nxt    = 1'b0;
            if (in_data.test_kind != KIND_NONE) begin
              kind_nxt  = in_data.test_kind;
              start_nxt = in_data.now_ms;
              last_nxt  = in_data.now_ms;
            end
          end else if (kind_r != KIND_NONE) begin
            unique case (in_data.command)
              CMD_PHASE: begin
                if (kind_r == KIND_RECOVERY && ph_map == PH_RECOVER &&
                    phase_r != PH_RECOVER) begin
                  armed_nxt    = 1'b1;
                  hr_first_nxt = '0;
                  hr_last_nxt  = '0;
                end
                phase_nxt = ph_map;
              end
              CMD_SAMPLE: begin
                if (kind_r == KIND_RECOVERY && phase_r == PH_RECOVER &&
                    in_data.heart_rate != '0) begin
                  if (armed_r && hr_first_r == '0) hr_first_nxt = in_data.heart_rate;
                  hr_last_nxt = in_data.heart_rate;
                end
                if (gap_ok) begin
                  last_nxt = in_data.now_ms;
                  if (in_data.power_watts > peak_r) peak_nxt = in_data.power_watts;
                  if (phase_r == PH_MAIN) begin
                    mtot_nxt = msum[32] ? 32'hFFFF_FFFF : msum[31:0];
                    if (mcnt_r != 16'hFFFF) mcnt_nxt = mcnt_r + 1'b1;
                  end
                  // old entry at pos is read at this edge
                  st_nxt = S_SMP_UPD;
                end
              end
              CMD_FINALIZE: begin
                avg_nxt   = '0;
                ftp_nxt   = '0;
                grade_nxt = '0;
                dur_nxt   = '0;
                st_nxt    = S_FB_GO;
              end
              default: begin
              end
            endcase
          end
        end
      end

      S_SMP_UPD: begin
        total_nxt = tot_upd;
        fill_nxt  = fill_upd;
        pos_nxt   = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
        if (fill_upd == WIN_FULL) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_NUM_W'(tot_upd);
          div_req.divisor  = WIN_DIV;
          st_nxt           = S_WIN_WT;
        end else begin
          st_nxt = S_IDLE;
        end
      end

      S_WIN_WT: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient[11:0] > best_r) best_nxt = div_rsp.quotient[11:0];
          st_nxt = S_IDLE;
        end
      end

      S_FB_GO: begin
        // ramp without a full window falls back to the partial mean
        if (kind_r == KIND_RAMP && best_r == '0 && fill_r != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_NUM_W'(total_r);
          div_req.divisor  = DIV_DEN_W'(fill_r);
          st_nxt           = S_FB_WT;
        end else begin
          st_nxt = S_AVG_GO;
        end
      end

      S_FB_WT: begin
        if (div_rsp.done) begin
          best_nxt = div_rsp.quotient[11:0];
          st_nxt   = S_AVG_GO;
        end
      end

      S_AVG_GO: begin
        if (mcnt_r != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = mtot_r;
          div_req.divisor  = mcnt_r;
          st_nxt           = S_AVG_WT;
        end else begin
          st_nxt = S_FTP_GO;
        end
      end

      S_AVG_WT: begin
        if (div_rsp.done) begin
          avg_nxt = (div_rsp.quotient > DIV_NUM_W'(WATTS_MAX)) ? WATTS_MAX
                                                               : div_rsp.quotient[11:0];
          st_nxt  = S_FTP_GO;
        end
      end

      S_FTP_GO: begin
        mean_nxt = (kind_r == KIND_RAMP && best_r == '0) ? peak_r : best_r;
        if (ftp_val != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_NUM_W'(20'(ftp_prod) + PCT_ROUND);
          div_req.divisor  = PCT_DIV;
          st_nxt           = S_FTP_WT;
        end else begin
          st_nxt = S_GRD_GO;
        end
      end

      S_FTP_WT: begin
        if (div_rsp.done) begin
          ftp_nxt = (div_rsp.quotient > DIV_NUM_W'(WATTS_MAX)) ? WATTS_MAX
                                                               : div_rsp.quotient[11:0];
          st_nxt  = S_GRD_GO;
        end
      end

      S_GRD_GO: begin
        if (grade_ok && drop_r == '0) begin
          grade_nxt = GRADE_MAX;
          st_nxt    = S_DUR_GO;
        end else if (grade_ok) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_NUM_W'(hr_drop) * DIV_NUM_W'(GRADE_STEPS);
          div_req.divisor  = DIV_DEN_W'(drop_r);
          st_nxt           = S_GRD_WT;
        end else begin
          st_nxt = S_DUR_GO;
        end
      end

      S_GRD_WT: begin
        if (div_rsp.done) begin
          grade_nxt = (div_rsp.quotient >= DIV_NUM_W'(GRADE_STEPS)) ? GRADE_MAX
                      : div_rsp.quotient[3:0] + 1'b1;
          st_nxt    = S_DUR_GO;
        end
      end

      S_DUR_GO: begin
        if (start_r != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = in_r.now_ms - start_r;
          div_req.divisor  = MS_PER_S;
          st_nxt           = S_DUR_WT;
        end else begin
          st_nxt = S_OUT;
        end
      end

      S_DUR_WT: begin
        if (div_rsp.done) begin
          dur_nxt = div_rsp.quotient[22:0];
          st_nxt  = S_OUT;
        end
      end

      S_OUT: begin
        // hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          out_nxt.result_kind       = kind_r;
          out_nxt.peak_watts        = peak_r;
          out_nxt.best_mean_watts   = mean_r;
          out_nxt.main_avg_watts    = avg_r;
          out_nxt.main_sample_count = mcnt_r;
          out_nxt.hr_at_load        = hr_first_r;
          out_nxt.hr_at_recover     = hr_last_r;
          out_nxt.ftp_proposal      = ftp_r;
          out_nxt.recovery_grade    = grade_r;
          out_nxt.duration_s        = dur_r;
          out_valid_nxt             = 1'b1;
          kind_nxt                  = KIND_NONE;
          phase_nxt                 = PH_IDLE;
          st_nxt                    = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r      <= GAP_RST;
      ramp_pct_r <= RAMP_PCT_RST;
      long_pct_r <= LONG_PCT_RST;
      drop_r     <= DROP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MIN_GAP:   gap_r      <= cfg_wdata;
        CFG_RAMP_PCT:  ramp_pct_r <= cfg_wdata[6:0];
        CFG_LONG_PCT:  long_pct_r <= cfg_wdata[6:0];
        CFG_FULL_DROP: drop_r     <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      kind_r      <= KIND_NONE;
      phase_r     <= PH_IDLE;
      start_r     <= '0;
      last_r      <= '0;
      pos_r       <= '0;
      fill_r      <= '0;
      total_r     <= '0;
      best_r      <= '0;
      mtot_r      <= '0;
      mcnt_r      <= '0;
      peak_r      <= '0;
      hr_first_r  <= '0;
      hr_last_r   <= '0;
      armed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      kind_r      <= kind_nxt;
      phase_r     <= phase_nxt;
      start_r     <= start_nxt;
      last_r      <= last_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      best_r      <= best_nxt;
      mtot_r      <= mtot_nxt;
      mcnt_r      <= mcnt_nxt;
      peak_r      <= peak_nxt;
      hr_first_r  <= hr_first_nxt;
      hr_last_r   <= hr_last_nxt;
      armed_r     <= armed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (acc) in_r <= in_data;
    mean_r  <= mean_nxt;
    avg_r   <= avg_nxt;
    ftp_r   <= ftp_nxt;
    grade_r <= grade_nxt;
    dur_r   <= dur_nxt;
    out_r   <= out_nxt;
  end

  // window memory, registered read
  always_ff @(posedge clk) begin
    if (st_r == S_SMP_UPD) win_mem[pos_r] <= in_r.power_watts;
    rd_r <= win_mem[pos_r];
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= WIN_FULL && pos_r <= POS_LAST) else $error("window index out of range");

  a_out_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.result_kind != KIND_NONE && out_r.recovery_grade <= GRADE_MAX)
    else $error("bad result beat");

  a_out_clears_test: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT && st_nxt == S_IDLE) |=> kind_r == KIND_NONE && out_valid_r)
    else $error("finalize did not close the test");

  a_div_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> st_r != S_IDLE) else $error("divider result while idle");

endmodule

`default_nettype wire

>>> src/pts_div.sv
// ----------------------------------------------------------------------------
// pts_div: shared restoring divider
// Unsigned 32 by 16 bit division, one quotient bit per cycle. The result
// shows with a one-cycle done pulse after the last quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pts_pkg::div_req_t req,
  output pts_pkg::div_rsp_t      rsp
);
  import pts_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_NUM_W);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIV_NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  assign trial = {rem_r, quo_r[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_NUM_W - 1);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when it fits
      quo_nxt = {quo_r[DIV_NUM_W-2:0], fits};
      rem_nxt = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("divider started while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r && !done_r) else $error("divider did not start");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r)) else $error("done without a run");

endmodule

`default_nettype wire

>>> bench/power_test_statistics_unit_test.sv
// ----------------------------------------------------------------------------
// power_test_statistics_unit_test: self-checking bench for the power test unit
// Drives command beats (start, phase, sample, finalize) through the valid and
// stall handshake. A scoring model runs alongside the unit and predicts each
// finalize score, and every result beat is checked field by field. A short
// directed part comes first, then well-formed random test sessions mixed with
// noise, under several register settings and three idle profiles.
// ----------------------------------------------------------------------------
module power_test_statistics_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pts_pkg::*;

  localparam int unsigned WINDOW        = 60;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned LIMIT_CYCLES  = 1500000;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_GAP;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  power_test_statistics_unit #(.WINDOW(WINDOW)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Register copies
  logic [15:0] gap_cfg;
  logic [6:0]  ramp_pct_cfg;
  logic [6:0]  long_pct_cfg;
  logic [7:0]  full_drop_cfg;

  // Test statistics tracked by the scoring model
  logic [1:0]        run_kind;
  logic [2:0]        run_phase;
  logic [31:0]       t_start;
  logic [31:0]       t_last;
  logic [11:0]       win_mem [WINDOW];
  int unsigned       win_pos;
  int unsigned       win_fill;
  int unsigned       win_sum;
  int unsigned       best_avg;
  longint unsigned   main_sum;
  int unsigned       main_n;
  int unsigned       peak_w;
  logic [7:0]        hr_first_seen;
  logic [7:0]        hr_last_seen;
  bit                hr_armed;

  out_item_t   pending_scores [$];
  out_item_t   oldest_score;
  int unsigned error_count = 0;
  int unsigned items_sent  = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic [31:0] wall_ms;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- model --

  function automatic void clear_run();
    run_kind      = KIND_NONE;
    run_phase     = PH_IDLE;
    t_start       = '0;
    t_last        = '0;
    foreach (win_mem[i]) win_mem[i] = '0;
    win_pos       = 0;
    win_fill      = 0;
    win_sum       = 0;
    best_avg      = 0;
    main_sum      = 0;
    main_n        = 0;
    peak_w        = 0;
    hr_first_seen = '0;
    hr_last_seen  = '0;
    hr_armed      = 1'b0;
  endfunction

  function automatic int unsigned percent_of(input int unsigned v, input logic [6:0] pct);
    int unsigned r;
    if (v == 0) return 0;
    r = (v * pct + 50) / 100;
    return (r > 4095) ? 4095 : r;
  endfunction

  function automatic void score_command(input in_item_t b);
    logic [31:0] since;
    logic [2:0]  next_phase;
    int unsigned mean;
    int unsigned avg;
    int unsigned ftp;
    int unsigned grade;
    int unsigned drop;
    out_item_t   s;
    if (b.command == CMD_START) begin
      clear_run();
      if (b.test_kind != KIND_NONE) begin
        run_kind = b.test_kind;
        t_start  = b.now_ms;
        t_last   = b.now_ms;
      end
    end else if (run_kind == KIND_NONE) begin
      // no test running: drop the beat
    end else if (b.command == CMD_PHASE) begin
      if (run_kind == KIND_RAMP) next_phase = PH_MAIN;
      else if (run_kind == KIND_LONG)
        next_phase = (b.phase_code <= PH_COOL) ? b.phase_code : PH_WARMUP;
      else next_phase = (b.phase_code == PH_RECOVER) ? PH_RECOVER : PH_LOAD;
      if (run_kind == KIND_RECOVERY && next_phase == PH_RECOVER && run_phase != PH_RECOVER) begin
        hr_armed      = 1'b1;
        hr_first_seen = '0;
        hr_last_seen  = '0;
      end
      run_phase = next_phase;
    end else if (b.command == CMD_SAMPLE) begin
      since = b.now_ms - t_last;
      if (t_last == 0 || since >= gap_cfg) begin
        t_last = b.now_ms;
        if (b.power_watts > peak_w) peak_w = b.power_watts;
        if (win_fill >= WINDOW) win_sum -= win_mem[win_pos];
        else win_fill++;
        win_mem[win_pos] = b.power_watts;
        win_sum += b.power_watts;
        win_pos = (win_pos + 1) % WINDOW;
        if (win_fill >= WINDOW && win_sum / WINDOW > best_avg) best_avg = win_sum / WINDOW;
        if (run_phase == PH_MAIN) begin
          main_sum = main_sum + b.power_watts;
          if (main_sum > 64'hFFFF_FFFF) main_sum = 64'hFFFF_FFFF;
          if (main_n < 65535) main_n++;
        end
      end
      // heart rate is captured even when the power is dropped
      if (run_kind == KIND_RECOVERY && run_phase == PH_RECOVER && b.heart_rate != 0) begin
        if (hr_armed && hr_first_seen == 0) hr_first_seen = b.heart_rate;
        hr_last_seen = b.heart_rate;
      end
    end else begin
      // ramp with no full window falls back to the partial-window mean
      if (run_kind == KIND_RAMP && best_avg == 0 && win_fill > 0) best_avg = win_sum / win_fill;
      mean  = best_avg;
      avg   = 0;
      ftp   = 0;
      grade = 0;
      if (main_n > 0) begin
        avg = int'(main_sum / main_n);
        if (avg > 4095) avg = 4095;
      end
      if (run_kind == KIND_RAMP) begin
        if (mean == 0) mean = peak_w;
        ftp = percent_of(mean, ramp_pct_cfg);
      end else if (run_kind == KIND_LONG) begin
        ftp = percent_of(avg, long_pct_cfg);
      end else if (hr_first_seen != 0 && hr_last_seen != 0 && hr_first_seen >= hr_last_seen) begin
        drop  = hr_first_seen - hr_last_seen;
        grade = (full_drop_cfg == 0) ? 10 : 1 + (drop * 9) / full_drop_cfg;
        if (grade > 10) grade = 10;
      end
      since               = b.now_ms - t_start;
      s.result_kind       = run_kind;
      s.peak_watts        = 12'(peak_w);
      s.best_mean_watts   = 12'(mean);
      s.main_avg_watts    = 12'(avg);
      s.main_sample_count = 16'(main_n);
      s.hr_at_load        = hr_first_seen;
      s.hr_at_recover     = hr_last_seen;
      s.ftp_proposal      = 12'(ftp);
      s.recovery_grade    = 4'(grade);
      s.duration_s        = (t_start == 0) ? 23'd0 : 23'(since / 1000);
      pending_scores.push_back(s);
      run_kind  = KIND_NONE;
      run_phase = PH_IDLE;
    end
  endfunction

  // --------------------------------------------------------------- driving --

  task automatic send_command(input in_item_t b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    score_command(b);
    items_sent++;
  endtask

  // Hold the sender until every score is back and the unit has settled.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_registers(input logic [15:0] gap, input logic [6:0] ramp_pct,
                                   input logic [6:0] long_pct, input logic [7:0] full_drop);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MIN_GAP;
    cfg_wdata <= gap;
    @(posedge clk);
    cfg_index <= CFG_RAMP_PCT;
    cfg_wdata <= 16'(ramp_pct);
    @(posedge clk);
    cfg_index <= CFG_LONG_PCT;
    cfg_wdata <= 16'(long_pct);
    @(posedge clk);
    cfg_index <= CFG_FULL_DROP;
    cfg_wdata <= 16'(full_drop);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    gap_cfg       = gap;
    ramp_pct_cfg  = ramp_pct;
    long_pct_cfg  = long_pct;
    full_drop_cfg = full_drop;
  endtask

  function automatic in_item_t make_beat(input logic [1:0] cmd, input logic [1:0] kind,
                                         input logic [2:0] code, input logic [11:0] watts,
                                         input logic [7:0] hr, input logic [31:0] now);
    in_item_t b;
    b.command     = cmd;
    b.test_kind   = kind;
    b.phase_code  = code;
    b.power_watts = watts;
    b.heart_rate  = hr;
    b.now_ms      = now;
    return b;
  endfunction

  function automatic in_item_t random_beat();
    return make_beat(2'($urandom), 2'($urandom), 3'($urandom), 12'($urandom),
                     8'($urandom), $urandom());
  endfunction

  function automatic void advance_clock();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 78) wall_ms = wall_ms + 32'(gap_cfg) + 32'($urandom_range(0, 700));
    else if (roll < 95) wall_ms = wall_ms + 32'($urandom_range(0, gap_cfg));
    else wall_ms = wall_ms + $urandom();
  endfunction

  function automatic logic [11:0] pick_watts();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return 12'd0;
    if (roll < 16) return 12'hFFF;
    return 12'($urandom);
  endfunction

  function automatic int unsigned pick_run_length(input int unsigned long_pct);
    if ($urandom_range(0, 99) < long_pct) return $urandom_range(55, 130);
    return $urandom_range(0, 8);
  endfunction

  function automatic logic [2:0] long_code(input logic [2:0] canon);
    if ($urandom_range(0, 3) != 0) return canon;
    return 3'($urandom);
  endfunction

  task automatic send_phase(input logic [2:0] code);
    in_item_t b;
    b            = random_beat();
    b.command    = CMD_PHASE;
    b.phase_code = code;
    send_command(b);
  endtask

  task automatic send_samples(input int unsigned count, input bit recovering);
    in_item_t    b;
    int unsigned hr_level;
    int unsigned roll;
    hr_level = $urandom_range(90, 255);
    repeat (count) begin
      advance_clock();
      b             = random_beat();
      b.command     = CMD_SAMPLE;
      b.now_ms      = wall_ms;
      b.power_watts = pick_watts();
      if (recovering) begin
        // drift the heart rate mostly down, now and then up or unknown
        roll = $urandom_range(0, 99);
        if (roll < 70) hr_level = (hr_level > 16) ? hr_level - $urandom_range(0, 15) : hr_level;
        else if (roll < 88) hr_level = (hr_level < 235) ? hr_level + $urandom_range(0, 20) : hr_level;
        b.heart_rate = (roll >= 92) ? 8'd0 : 8'(hr_level);
      end
      send_command(b);
    end
  endtask

  task automatic run_session();
    in_item_t   b;
    logic [1:0] kind;
    logic [2:0] code;
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 5)) send_command(random_beat());
    end else begin
      kind = 2'($urandom_range(1, 3));
      advance_clock();
      b           = random_beat();
      b.command   = CMD_START;
      b.test_kind = kind;
      b.now_ms    = ($urandom_range(0, 19) == 0) ? 32'd0 : wall_ms;
      send_command(b);
      case (kind)
        KIND_RAMP: begin
          if ($urandom_range(0, 3) != 0) send_phase(3'($urandom));
          send_samples(pick_run_length(25), 1'b0);
        end
        KIND_LONG: begin
          send_phase(long_code(PH_WARMUP));
          send_samples(pick_run_length(5), 1'b0);
          send_phase(long_code(PH_MAIN));
          send_samples(pick_run_length(10), 1'b0);
          send_phase(long_code(PH_COOL));
          send_samples(pick_run_length(0), 1'b0);
        end
        default: begin
          code = 3'($urandom);
          if (code == PH_RECOVER) code = PH_LOAD;
          send_phase(code);
          send_samples(pick_run_length(0), 1'b0);
          send_phase(PH_RECOVER);
          send_samples(pick_run_length(5), 1'b1);
          if ($urandom_range(0, 4) == 0) begin
            send_phase(PH_RECOVER);
            send_samples(pick_run_length(0), 1'b1);
          end
        end
      endcase
      // leave a few sessions open: the next start must clear them
      if ($urandom_range(0, 99) < 92) begin
        advance_clock();
        b         = random_beat();
        b.command = CMD_FINALIZE;
        b.now_ms  = wall_ms;
        send_command(b);
      end
    end
  endtask

  // --------------------------------------------------------------- checking --

  task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      if (error_count < 10)
        $display("mismatch in %s: expected %0d, got %0d", field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_scores.size() == 0) begin
        if (error_count < 10)
          $display("unexpected result beat: kind %0d peak %0d ftp %0d",
                   out_data.result_kind, out_data.peak_watts, out_data.ftp_proposal);
        error_count++;
      end else begin
        oldest_score = pending_scores.pop_front();
        check_field("result_kind", oldest_score.result_kind, out_data.result_kind);
        check_field("peak_watts", oldest_score.peak_watts, out_data.peak_watts);
        check_field("best_mean_watts", oldest_score.best_mean_watts, out_data.best_mean_watts);
        check_field("main_avg_watts", oldest_score.main_avg_watts, out_data.main_avg_watts);
        check_field("main_sample_count", oldest_score.main_sample_count,
                    out_data.main_sample_count);
        check_field("hr_at_load", oldest_score.hr_at_load, out_data.hr_at_load);
        check_field("hr_at_recover", oldest_score.hr_at_recover, out_data.hr_at_recover);
        check_field("ftp_proposal", oldest_score.ftp_proposal, out_data.ftp_proposal);
        check_field("recovery_grade", oldest_score.recovery_grade, out_data.recovery_grade);
        check_field("duration_s", oldest_score.duration_s, out_data.duration_s);
      end
    end
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // ------------------------------------------------------------------ tests --

  task automatic test_idle_commands();
    send_command(make_beat(CMD_FINALIZE, KIND_RECOVERY, 3'd7, 12'hFFF, 8'hFF, 32'hFFFF_FFFF));
    send_command(make_beat(CMD_SAMPLE, KIND_RAMP, PH_MAIN, 12'hFFF, 8'hFF, 32'd5000));
    send_command(make_beat(CMD_PHASE, KIND_LONG, PH_MAIN, 12'd0, 8'd0, 32'd6000));
    send_command(make_beat(CMD_START, KIND_NONE, PH_MAIN, 12'd0, 8'd0, 32'd7000));
  endtask

  // Ramp started at time zero: no gap check before the first kept beat, no main sum
  // without a phase command, partial-window mean, and an empty ramp falling to peak.
  task automatic test_ramp_partial_window();
    send_command(make_beat(CMD_START, KIND_RAMP, PH_WARMUP, 12'd0, 8'd0, 32'd0));
    send_command(make_beat(CMD_SAMPLE, KIND_NONE, PH_WARMUP, 12'hFFF, 8'hFF, 32'd5));
    send_command(make_beat(CMD_SAMPLE, KIND_NONE, PH_WARMUP, 12'd0, 8'd0, 32'd10));
    send_command(make_beat(CMD_SAMPLE, KIND_NONE, PH_WARMUP, 12'd0, 8'd0, 32'd2000));
    send_command(make_beat(CMD_FINALIZE, KIND_NONE, PH_WARMUP, 12'd0, 8'd0, 32'd7000));
    send_command(make_beat(CMD_START, KIND_RAMP, PH_WARMUP, 12'd0, 8'd0, 32'd50));
    send_command(make_beat(CMD_FINALIZE, KIND_NONE, PH_WARMUP, 12'd0, 8'd0, 32'd50));
  endtask

  // Phase codes past cooldown map to warmup; time wraps through zero.
  task automatic test_long_phases();
    send_command(make_beat(CMD_START, KIND_LONG, PH_WARMUP, 12'd0, 8'd0, 32'hFFFF_F000));
    send_command(make_beat(CMD_PHASE, KIND_NONE, 3'd7, 12'd0, 8'd0, 32'd0));
    send_command(make_beat(CMD_SAMPLE, KIND_NONE, PH_WARMUP, 12'd1000, 8'd90, 32'hFFFF_F3E8));
    send_command(make_beat(CMD_PHASE, KIND_NONE, PH_MAIN, 12'd0, 8'd0, 32'd0));
    send_command(make_beat(CMD_SAMPLE, KIND_NONE, PH_WARMUP, 12'hFFF, 8'd160, 32'h0000_0200));
    send_command(make_beat(CMD_PHASE, KIND_NONE, PH_COOL, 12'd0, 8'd0, 32'd0));
    send_command(make_beat(CMD_FINALIZE, KIND_NONE, PH_WARMUP, 12'd0, 8'd0, 32'h0000_2000));
  endtask

  // Unknown heart rate is skipped, a dropped power beat still updates the heart
  // rate, and a large drop caps the grade.
  task automatic test_recovery_grade();
    send_command(make_beat(CMD_START, KIND_RECOVERY, PH_WARMUP, 12'd0, 8'd0, 32'd1234));
    send_command(make_beat(CMD_PHASE, KIND_NONE, PH_WARMUP, 12'd0, 8'd0, 32'd0));
    send_command(make_beat(CMD_SAMPLE, KIND_NONE, PH_WARMUP, 12'd300, 8'd180, 32'd2500));
    send_command(make_beat(CMD_PHASE, KIND_NONE, PH_RECOVER, 12'd0, 8'd0, 32'd0));
    send_command(make_beat(CMD_SAMPLE, KIND_NONE, PH_WARMUP, 12'd200, 8'd0, 32'd3500));
    send_command(make_beat(CMD_SAMPLE, KIND_NONE, PH_WARMUP, 12'd150, 8'd170, 32'd4500));
    send_command(make_beat(CMD_SAMPLE, KIND_NONE, PH_WARMUP, 12'd900, 8'd120, 32'd4600));
    send_command(make_beat(CMD_FINALIZE, KIND_NONE, PH_WARMUP, 12'd0, 8'd0, 32'd9000));
  endtask

  task automatic test_register_extremes();
    wait_until_idle();
    program_registers(16'd0, 7'd100, 7'd0, 8'd1);
    repeat (6) run_session();
    wait_until_idle();
    program_registers(16'hFFFF, 7'd0, 7'd100, 8'd255);
    repeat (6) run_session();
    // percentages past 100 reach the FTP clamp; a zero drop gives the top grade
    wait_until_idle();
    program_registers(16'd900, 7'd127, 7'd127, 8'd0);
    repeat (6) run_session();
  endtask

  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input int unsigned count);
    int unsigned goal;
    int unsigned sessions;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    goal        = items_sent + count;
    sessions    = 0;
    while (items_sent < goal) begin
      if (sessions % 10 == 0) begin
        wait_until_idle();
        program_registers(($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 2000)),
                          7'($urandom_range(0, 100)), 7'($urandom_range(0, 100)),
                          8'($urandom_range(1, 255)));
      end
      run_session();
      sessions++;
    end
  endtask

  initial begin
    gap_cfg       = GAP_RST;
    ramp_pct_cfg  = RAMP_PCT_RST;
    long_pct_cfg  = LONG_PCT_RST;
    full_drop_cfg = DROP_RST;
    clear_run();
    wall_ms       = $urandom();
    tx_idle_pct   = 37;
    rx_idle_pct   = 66;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_commands();
    test_ramp_partial_window();
    test_long_phases();
    test_recovery_grade();
    test_register_extremes();
    test_random_traffic(37, 66, 650);
    test_random_traffic(66, 37, 650);
    test_random_traffic(0, 0, 650);

    wait_until_idle();
    if (error_count == 0 && pending_scores.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
src/pts_pkg.sv
src/pts_div.sv
src/power_test_statistics_unit.sv
bench/power_test_statistics_unit_test.sv
